@@ hdl/i2cmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types, codes and sequencing functions shared by the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

   // most phases a single tick can pass through, including the end check
   localparam int unsigned SEQ_STEPS = 6;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_WRITE     = 3'd3,
      CMD_READ      = 3'd4,
      CMD_GET_ACK   = 3'd5,
      CMD_SEND_ACK  = 3'd6,
      CMD_SEND_NACK = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_CLOCK_LOW  = 3'd0,
      CSR_CLOCK_HIGH = 3'd1,
      CSR_HALF_CLOCK = 3'd2,
      CSR_SETTLE     = 3'd3,
      CSR_START      = 3'd4,
      CSR_STOP       = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_ST0  = 5'd1,
      PH_ST1  = 5'd2,
      PH_ST2  = 5'd3,
      PH_SP0  = 5'd4,
      PH_SP1  = 5'd5,
      PH_WR0  = 5'd6,
      PH_WR1  = 5'd7,
      PH_WR2  = 5'd8,
      PH_WR3  = 5'd9,
      PH_WR4  = 5'd10,
      PH_RD0  = 5'd11,
      PH_RD1  = 5'd12,
      PH_RD2  = 5'd13,
      PH_RD3  = 5'd14,
      PH_RD4  = 5'd15,
      PH_GA0  = 5'd16,
      PH_GA1  = 5'd17,
      PH_GA2  = 5'd18,
      PH_GA3  = 5'd19,
      PH_SA0  = 5'd20,
      PH_SN0  = 5'd21,
      PH_SK1  = 5'd22,
      PH_SK2  = 5'd23,
      PH_SK3  = 5'd24,
      PH_SK4  = 5'd25,
      PH_END  = 5'd26
   } phase_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_released;
      logic       sda_released;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_ok;
   } rsp_type;

   typedef struct packed {
      logic [7:0] clock_low_ticks;
      logic [7:0] clock_high_ticks;
      logic [7:0] half_clock_ticks;
      logic [7:0] settle_ticks;
      logic [7:0] start_ticks;
      logic [7:0] stop_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      clock_low_ticks:  8'd5,
      clock_high_ticks: 8'd5,
      half_clock_ticks: 8'd3,
      settle_ticks:     8'd2,
      start_ticks:      8'd5,
      stop_ticks:       8'd5
   };

   typedef struct packed {
      phase_type  phase;
      logic [7:0] delay;
      logic [3:0] bit_count;
      logic [7:0] shift;
      logic       scl;
      logic       sda;
      logic       ack;
      logic [7:0] last_read;
   } core_type;

   typedef struct packed {
      core_type core;
      logic     done;
      logic     halted;
   } step_type;

   function automatic phase_type entry_phase(logic [2:0] cmd);
      phase_type p;
      case (cmd)
         CMD_START:     p = PH_ST0;
         CMD_STOP:      p = PH_SP0;
         CMD_WRITE:     p = PH_WR0;
         CMD_READ:      p = PH_RD0;
         CMD_GET_ACK:   p = PH_GA0;
         CMD_SEND_ACK:  p = PH_SA0;
         CMD_SEND_NACK: p = PH_SN0;
         default:       p = PH_IDLE;
      endcase
      return p;
   endfunction

   function automatic phase_type successor(phase_type p, logic [3:0] bit_count);
      phase_type n;
      case (p)
         PH_ST0:  n = PH_ST1;
         PH_ST1:  n = PH_ST2;
         PH_SP0:  n = PH_SP1;
         PH_WR0:  n = PH_WR1;
         PH_WR1:  n = PH_WR2;
         PH_WR2:  n = PH_WR3;
         PH_WR3:  n = (bit_count != 4'd0) ? PH_WR1 : PH_WR4;
         PH_RD0:  n = PH_RD1;
         PH_RD1:  n = PH_RD2;
         PH_RD2:  n = PH_RD3;
         PH_RD3:  n = PH_RD4;
         PH_RD4:  n = (bit_count != 4'd0) ? PH_RD1 : PH_END;
         PH_GA0:  n = PH_GA1;
         PH_GA1:  n = PH_GA2;
         PH_GA2:  n = PH_GA3;
         PH_SA0:  n = PH_SK1;
         PH_SN0:  n = PH_SK1;
         PH_SK1:  n = PH_SK2;
         PH_SK2:  n = PH_SK3;
         PH_SK3:  n = PH_SK4;
         default: n = PH_END;
      endcase
      return n;
   endfunction

   // shift left by n bit times, filling with one level; a count of zero wraps to sixteen
   function automatic logic [7:0] shift_fill(logic [7:0] v, logic [3:0] n, logic fill);
      logic [7:0] r;
      if (n == 4'd0 || n[3]) begin
         r = {8{fill}};
      end else begin
         r = (v << n[2:0]) | (fill ? ~(8'hFF << n[2:0]) : 8'h00);
      end
      return r;
   endfunction

   // one phase of the sequencer: entry action, then a wait, the next phase, a jump or the end
   function automatic step_type seq_step(step_type s, cfg_type c, logic sda_in);
      step_type   r;
      logic [7:0] w;
      logic       early;
      logic       jump;
      phase_type  target;
      logic [3:0] bc_dec;
      r      = s;
      w      = 8'd0;
      early  = 1'b0;
      jump   = 1'b0;
      target = PH_END;
      bc_dec = s.core.bit_count - 4'd1;
      if (!s.halted) begin
         if (s.core.phase == PH_IDLE || s.core.phase == PH_END) begin
            r.done       = 1'b1;
            r.halted     = 1'b1;
            r.core.phase = PH_IDLE;
            r.core.delay = 8'd0;
         end else begin
            case (s.core.phase)
               PH_ST0: begin
                  r.core.scl = 1'b1;
                  r.core.sda = 1'b1;
                  w = c.start_ticks;
               end
               PH_ST1: begin
                  r.core.sda = 1'b0;
                  w = c.start_ticks;
               end
               PH_ST2: begin
                  r.core.scl = 1'b0;
                  w = c.clock_low_ticks;
               end
               PH_SP0: begin
                  r.core.sda = 1'b0;
                  r.core.scl = 1'b1;
                  w = c.stop_ticks;
               end
               PH_SP1: r.core.sda = 1'b1;
               PH_WR0: begin
                  r.core.bit_count = 4'd8;
                  w = c.clock_low_ticks;
               end
               PH_WR1: begin
                  if (c.settle_ticks == 8'd0 && c.clock_high_ticks == 8'd0 &&
                      c.clock_low_ticks == 8'd0) begin
                     // no waits in the bit loop: all remaining bits go out this tick
                     r.core.shift     = shift_fill(s.core.shift, s.core.bit_count, 1'b0);
                     r.core.bit_count = 4'd0;
                     r.core.scl       = 1'b0;
                     r.core.sda       = 1'b1;
                     jump   = 1'b1;
                     target = PH_WR4;
                  end else begin
                     r.core.sda   = s.core.shift[7];
                     r.core.shift = {s.core.shift[6:0], 1'b0};
                     w = c.settle_ticks;
                  end
               end
               PH_WR2: begin
                  r.core.scl = 1'b1;
                  w = c.clock_high_ticks;
               end
               PH_WR3: begin
                  r.core.scl       = 1'b0;
                  r.core.bit_count = bc_dec;
                  w = c.clock_low_ticks;
               end
               PH_WR4: r.core.sda = 1'b1;
               PH_RD0: begin
                  r.core.bit_count = 4'd8;
                  r.core.shift     = 8'd0;
                  w = c.clock_low_ticks;
               end
               PH_RD1: begin
                  if (c.settle_ticks == 8'd0 && c.half_clock_ticks == 8'd0 &&
                      c.clock_low_ticks == 8'd0) begin
                     // no waits in the bit loop: every remaining bit samples this level
                     r.core.shift     = shift_fill(s.core.shift, s.core.bit_count, sda_in);
                     r.core.last_read = r.core.shift;
                     r.core.bit_count = 4'd0;
                     r.core.scl       = 1'b0;
                     r.core.sda       = 1'b1;
                     jump   = 1'b1;
                     target = PH_END;
                  end else begin
                     r.core.shift = {s.core.shift[6:0], 1'b0};
                     r.core.sda   = 1'b1;
                     w = c.settle_ticks;
                  end
               end
               PH_RD2: begin
                  r.core.scl = 1'b1;
                  w = c.half_clock_ticks;
               end
               PH_RD3: begin
                  r.core.shift = {s.core.shift[7:1], s.core.shift[0] | sda_in};
                  w = c.half_clock_ticks;
               end
               PH_RD4: begin
                  r.core.scl       = 1'b0;
                  r.core.bit_count = bc_dec;
                  if (bc_dec == 4'd0) begin
                     r.core.last_read = s.core.shift;
                  end
                  w = c.clock_low_ticks;
               end
               PH_GA0: begin
                  r.core.sda = 1'b1;
                  r.core.scl = 1'b1;
                  w = c.half_clock_ticks;
               end
               PH_GA1: begin
                  if (sda_in) begin
                     r.core.ack = 1'b0;
                     early = 1'b1;
                  end else begin
                     r.core.ack = 1'b1;
                     w = c.half_clock_ticks;
                  end
               end
               PH_GA2: begin
                  r.core.scl = 1'b0;
                  w = c.clock_low_ticks;
               end
               PH_GA3: w = c.clock_low_ticks;
               PH_SA0: begin
                  r.core.sda = 1'b0;
                  w = c.settle_ticks;
               end
               PH_SN0: begin
                  r.core.sda = 1'b1;
                  w = c.settle_ticks;
               end
               PH_SK1: w = c.settle_ticks;
               PH_SK2: begin
                  r.core.scl = 1'b1;
                  w = c.clock_high_ticks;
               end
               PH_SK3: begin
                  r.core.scl = 1'b0;
                  w = c.clock_low_ticks;
               end
               PH_SK4: begin
                  r.core.sda = 1'b1;
                  w = c.settle_ticks;
               end
               default: early = 1'b1;
            endcase
            if (jump) begin
               r.core.phase = target;
            end else if (early) begin
               r.core.phase = PH_END;
            end else if (w != 8'd0) begin
               r.halted     = 1'b1;
               r.core.delay = w - 8'd1;
            end else begin
               r.core.phase = successor(s.core.phase, r.core.bit_count);
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/i2c_master_bit_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master bit sequencer: one request is one delay tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_type: command, write_byte, sda_in
//  rsp     | out       | rsp_valid/rsp_stall | rsp_type: pin states, busy, done, byte, ack
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data (8 bit delay)
//
//  one tick per clock when the response side is not stalled; each tick passes through
//  the request register, then the response register
//  all phases that have no wait left are walked through in the tick that reaches them
//  reset: bus released, sequencer idle, delays back to their default values
//  a stalled response holds the request register, which then stalls req
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine import i2cmbe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_data,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_data
);

   logic     req_vld_ff;
   req_type  req_data_ff;
   logic     rsp_vld_ff;
   rsp_type  rsp_data_ff;
   rsp_type  rsp_data_in;
   cfg_type  cfg_ff;
   core_type state_ff;
   core_type state_in;
   logic     advance;
   logic     run;
   step_type chain [0:SEQ_STEPS];

   assign advance   = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLOCK_LOW:  cfg_ff.clock_low_ticks  <= csr_data;
            CSR_CLOCK_HIGH: cfg_ff.clock_high_ticks <= csr_data;
            CSR_HALF_CLOCK: cfg_ff.half_clock_ticks <= csr_data;
            CSR_SETTLE:     cfg_ff.settle_ticks     <= csr_data;
            CSR_START:      cfg_ff.start_ticks      <= csr_data;
            CSR_STOP:       cfg_ff.stop_ticks       <= csr_data;
            default: ;
         endcase
      end
   end

   // tick sequencing
   always_comb begin
      chain[0]        = '0;
      chain[0].core   = state_ff;
      chain[0].halted = 1'b1;
      run             = 1'b0;
      if (state_ff.phase == PH_IDLE) begin
         if (req_data_ff.command != CMD_NONE) begin
            run                   = 1'b1;
            chain[0].halted       = 1'b0;
            chain[0].core.phase   = entry_phase(req_data_ff.command);
            if (req_data_ff.command == CMD_WRITE) begin
               chain[0].core.shift = req_data_ff.write_byte;
            end
         end
      end else if (state_ff.delay != 8'd0) begin
         chain[0].core.delay = state_ff.delay - 8'd1;
      end else begin
         run                 = 1'b1;
         chain[0].halted     = 1'b0;
         chain[0].core.phase = successor(state_ff.phase, state_ff.bit_count);
      end
      for (int i = 0; i < SEQ_STEPS; i++) begin
         chain[i + 1] = seq_step(chain[i], cfg_ff, req_data_ff.sda_in);
      end
      state_in = chain[SEQ_STEPS].core;

      rsp_data_in.scl_released = state_in.scl;
      rsp_data_in.sda_released = state_in.sda;
      rsp_data_in.busy_res     = (state_in.phase != PH_IDLE);
      rsp_data_in.done_res     = run && chain[SEQ_STEPS].done;
      rsp_data_in.read_byte    = state_in.last_read;
      rsp_data_in.ack_ok       = state_in.ack;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '{phase: PH_IDLE, delay: 8'd0, bit_count: 4'd0, shift: 8'd0,
                         scl: 1'b1, sda: 1'b1, ack: 1'b0, last_read: 8'd0};
      end else begin
         if (!req_stall) begin
            req_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_vld_ff)
      else $error("request stalled with an empty request register");

   a_wait_not_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.delay != 8'd0 |-> state_ff.phase != PH_IDLE)
      else $error("delay count left running while idle");

   a_busy_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_data_ff.busy_res == (state_ff.phase != PH_IDLE))
      else $error("busy flag disagrees with sequencer phase");

   a_idle_no_done: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.phase == PH_IDLE && req_data_ff.command == CMD_NONE
      |=> !rsp_data_ff.done_res)
      else $error("done reported without a command");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_data_ff.done_res && rsp_data_ff.busy_res))
      else $error("sequence both finished and busy");

endmodule

`default_nettype wire

@@ tb/i2c_master_bit_engine_tb.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Self-checking bench for the I2C master bit engine. Each request is one bus
// tick; a bus model in the bench tracks the sequencer state and predicts the
// pin, busy, done, read byte and ack outputs of every tick. Stimulus is a
// short directed pass, then I2C transactions with random content and noise
// commands, run across several delay settings including all-zero and all-max.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cmbe_pkg::*;

   localparam logic [2:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [2:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int IDLE_PERCENT = 31;
   localparam int QUIET_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 80;
   localparam int CALM_FROM    = 700;
   localparam int CALM_TO      = 900;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] wait_left;
      logic [3:0] bits_left;
      logic [7:0] shifter;
      logic       scl;
      logic       sda;
      logic       ack;
      logic       done;
      logic [7:0] last_byte;
   } bus_state_type;

   typedef struct {
      req_type req;
      bit      pause;
   } tick_item_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_data  = '0;

   cfg_type       bus_cfg;
   bus_state_type gen_state;
   bus_state_type model_state;
   tick_item_type tick_queue[$];
   rsp_type       bus_forecast[$];

   int      pushed_ticks = 0;
   int      sent_ticks   = 0;
   int      got_results  = 0;
   int      errors       = 0;
   int      hold_left    = 0;
   int      next_hold    = 300;
   int      quiet        = 0;
   bit      pause_next   = 1'b0;
   bit      paused_once  = 1'b0;
   cmd_type last_cmd     = CMD_NONE;

   i2c_master_bit_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit calm(int n);
      return n >= CALM_FROM && n < CALM_TO;
   endfunction

   function automatic phase_type next_phase(phase_type p, logic [3:0] bits);
      phase_type n;
      case (p)
         PH_ST0:  n = PH_ST1;
         PH_ST1:  n = PH_ST2;
         PH_SP0:  n = PH_SP1;
         PH_WR0:  n = PH_WR1;
         PH_WR1:  n = PH_WR2;
         PH_WR2:  n = PH_WR3;
         PH_WR3:  n = (bits != 4'd0) ? PH_WR1 : PH_WR4;
         PH_RD0:  n = PH_RD1;
         PH_RD1:  n = PH_RD2;
         PH_RD2:  n = PH_RD3;
         PH_RD3:  n = PH_RD4;
         PH_RD4:  n = (bits != 4'd0) ? PH_RD1 : PH_END;
         PH_GA0:  n = PH_GA1;
         PH_GA1:  n = PH_GA2;
         PH_GA2:  n = PH_GA3;
         PH_SA0:  n = PH_SK1;
         PH_SN0:  n = PH_SK1;
         PH_SK1:  n = PH_SK2;
         PH_SK2:  n = PH_SK3;
         PH_SK3:  n = PH_SK4;
         default: n = PH_END;
      endcase
      return n;
   endfunction

   // one tick of the sequencer: phases with no wait are walked through at once
   function automatic bus_state_type advance_bus(bus_state_type s, req_type r, cfg_type c);
      bus_state_type n;
      phase_type     p;
      logic [7:0]    w;
      bit            walking;
      bit            early;
      n       = s;
      n.done  = 1'b0;
      walking = 1'b0;
      p       = PH_IDLE;
      if (s.phase == PH_IDLE) begin
         if (r.command != CMD_NONE) begin
            walking = 1'b1;
            if (r.command == CMD_WRITE) begin
               n.shifter = r.write_byte;
            end
            case (r.command)
               CMD_START:     p = PH_ST0;
               CMD_STOP:      p = PH_SP0;
               CMD_WRITE:     p = PH_WR0;
               CMD_READ:      p = PH_RD0;
               CMD_GET_ACK:   p = PH_GA0;
               CMD_SEND_ACK:  p = PH_SA0;
               default:       p = PH_SN0;
            endcase
         end
      end else if (s.wait_left != 8'd0) begin
         n.wait_left = s.wait_left - 8'd1;
      end else begin
         walking = 1'b1;
         p = next_phase(s.phase, s.bits_left);
      end
      while (walking) begin
         if (p == PH_END || p == PH_IDLE) begin
            n.done      = 1'b1;
            n.phase     = PH_IDLE;
            n.wait_left = 8'd0;
            walking     = 1'b0;
         end else begin
            n.phase = p;
            w       = 8'd0;
            early   = 1'b0;
            case (p)
               PH_ST0: begin
                  n.scl = 1'b1;
                  n.sda = 1'b1;
                  w = c.start_ticks;
               end
               PH_ST1: begin
                  n.sda = 1'b0;
                  w = c.start_ticks;
               end
               PH_ST2: begin
                  n.scl = 1'b0;
                  w = c.clock_low_ticks;
               end
               PH_SP0: begin
                  n.sda = 1'b0;
                  n.scl = 1'b1;
                  w = c.stop_ticks;
               end
               PH_SP1: n.sda = 1'b1;
               PH_WR0: begin
                  n.bits_left = 4'd8;
                  w = c.clock_low_ticks;
               end
               PH_WR1: begin
                  n.sda     = n.shifter[7];
                  n.shifter = {n.shifter[6:0], 1'b0};
                  w = c.settle_ticks;
               end
               PH_WR2: begin
                  n.scl = 1'b1;
                  w = c.clock_high_ticks;
               end
               PH_WR3: begin
                  n.scl       = 1'b0;
                  n.bits_left = n.bits_left - 4'd1;
                  w = c.clock_low_ticks;
               end
               PH_WR4: n.sda = 1'b1;
               PH_RD0: begin
                  n.bits_left = 4'd8;
                  n.shifter   = 8'd0;
                  w = c.clock_low_ticks;
               end
               PH_RD1: begin
                  n.shifter = {n.shifter[6:0], 1'b0};
                  n.sda     = 1'b1;
                  w = c.settle_ticks;
               end
               PH_RD2: begin
                  n.scl = 1'b1;
                  w = c.half_clock_ticks;
               end
               PH_RD3: begin
                  n.shifter[0] = n.shifter[0] | r.sda_in;
                  w = c.half_clock_ticks;
               end
               PH_RD4: begin
                  n.scl       = 1'b0;
                  n.bits_left = n.bits_left - 4'd1;
                  if (n.bits_left == 4'd0) begin
                     n.last_byte = n.shifter;
                  end
                  w = c.clock_low_ticks;
               end
               PH_GA0: begin
                  n.sda = 1'b1;
                  n.scl = 1'b1;
                  w = c.half_clock_ticks;
               end
               PH_GA1: begin
                  // no ack: give up straight away, scl stays released
                  if (r.sda_in) begin
                     n.ack = 1'b0;
                     early = 1'b1;
                  end else begin
                     n.ack = 1'b1;
                     w = c.half_clock_ticks;
                  end
               end
               PH_GA2: begin
                  n.scl = 1'b0;
                  w = c.clock_low_ticks;
               end
               PH_GA3: w = c.clock_low_ticks;
               PH_SA0: begin
                  n.sda = 1'b0;
                  w = c.settle_ticks;
               end
               PH_SN0: begin
                  n.sda = 1'b1;
                  w = c.settle_ticks;
               end
               PH_SK1: w = c.settle_ticks;
               PH_SK2: begin
                  n.scl = 1'b1;
                  w = c.clock_high_ticks;
               end
               PH_SK3: begin
                  n.scl = 1'b0;
                  w = c.clock_low_ticks;
               end
               PH_SK4: begin
                  n.sda = 1'b1;
                  w = c.settle_ticks;
               end
               default: early = 1'b1;
            endcase
            if (early) begin
               p = PH_END;
            end else if (w != 8'd0) begin
               n.wait_left = w - 8'd1;
               walking     = 1'b0;
            end else begin
               p = next_phase(p, n.bits_left);
            end
         end
      end
      return n;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         if (errors < 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
         end
         errors++;
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : drive
      rsp_type want;
      bit      offer;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            model_state       = advance_bus(model_state, req_data, bus_cfg);
            want.scl_released = model_state.scl;
            want.sda_released = model_state.sda;
            want.busy_res     = (model_state.phase != PH_IDLE);
            want.done_res     = model_state.done;
            want.read_byte    = model_state.last_byte;
            want.ack_ok       = model_state.ack;
            bus_forecast.push_back(want);
            sent_ticks++;
         end
         if (!(req_valid && req_stall)) begin
            // a paused item waits until every outstanding result is back
            if (tick_queue.size() != 0 &&
                !(tick_queue[0].pause && bus_forecast.size() != 0)) begin
               offer = calm(sent_ticks) || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
            if (offer) begin
               req_data <= tick_queue[0].req;
               void'(tick_queue.pop_front());
            end
            req_valid <= offer;
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_results++;
            if (bus_forecast.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: result %h with none expected", $realtime, rsp_data);
               end
               errors++;
            end else begin
               want = bus_forecast.pop_front();
               check_field("scl_released", 8'(want.scl_released),
                           8'(rsp_data.scl_released));
               check_field("sda_released", 8'(want.sda_released),
                           8'(rsp_data.sda_released));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_data.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
               check_field("read_byte", want.read_byte, rsp_data.read_byte);
               check_field("ack_ok", 8'(want.ack_ok), 8'(rsp_data.ack_ok));
            end
         end
         // long hold-off so the engine backs up into the request side
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (got_results >= next_hold) begin
            rsp_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            next_hold += 900;
         end else begin
            rsp_stall <= !calm(got_results) && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // -------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // -------------------------------------------------------------- stimulus
   task automatic push_tick(cmd_type cmd, logic [7:0] data, logic sda);
      tick_item_type t;
      t.req.command    = cmd;
      t.req.write_byte = data;
      t.req.sda_in     = sda;
      t.pause          = pause_next;
      pause_next       = 1'b0;
      gen_state = advance_bus(gen_state, t.req, bus_cfg);
      tick_queue.push_back(t);
      pushed_ticks++;
   endtask

   // random byte and sda; during an ack check the slave mostly pulls sda low
   task automatic bus_tick(cmd_type cmd, bit force_high);
      logic sda;
      if (force_high) begin
         sda = 1'b1;
      end else if (last_cmd == CMD_GET_ACK) begin
         sda = ($urandom_range(0, 3) == 0);
      end else begin
         sda = 1'($urandom_range(0, 1));
      end
      push_tick(cmd, 8'($urandom_range(0, 255)), sda);
   endtask

   // run the bus model on until idle; commands given meanwhile are ignored
   task automatic settle_bus(bit force_high);
      while (gen_state.phase != PH_IDLE) begin
         if ($urandom_range(0, 4) == 0) begin
            bus_tick(cmd_type'($urandom_range(1, 7)), force_high);
         end else begin
            bus_tick(CMD_NONE, force_high);
         end
      end
   endtask

   task automatic issue(cmd_type cmd);
      cmd_type c;
      c = cmd;
      settle_bus(1'b0);
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) push_tick(CMD_NONE, 8'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1)));
      end
      // broken sequences now and then
      if ($urandom_range(0, 9) == 0) begin
         c = cmd_type'($urandom_range(0, 7));
      end
      if ((!paused_once && pushed_ticks > 100) || $urandom_range(0, 59) == 0) begin
         pause_next  = 1'b1;
         paused_once = 1'b1;
      end
      last_cmd = c;
      bus_tick(c, 1'b0);
   endtask

   task automatic run_transaction();
      issue(CMD_START);
      issue(CMD_WRITE);
      issue(CMD_GET_ACK);
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 1) == 1) begin
            issue(CMD_WRITE);
            issue(CMD_GET_ACK);
         end else begin
            issue(CMD_READ);
            issue($urandom_range(0, 1) ? CMD_SEND_ACK : CMD_SEND_NACK);
         end
      end
      issue(CMD_STOP);
   endtask

   task automatic bus_traffic(int count);
      int first;
      first = pushed_ticks;
      while (pushed_ticks - first < count) begin
         run_transaction();
      end
      settle_bus(1'b0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || bus_forecast.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CLOCK_LOW:  bus_cfg.clock_low_ticks  = val;
         CSR_CLOCK_HIGH: bus_cfg.clock_high_ticks = val;
         CSR_HALF_CLOCK: bus_cfg.half_clock_ticks = val;
         CSR_SETTLE:     bus_cfg.settle_ticks     = val;
         CSR_START:      bus_cfg.start_ticks      = val;
         CSR_STOP:       bus_cfg.stop_ticks       = val;
         default: ;
      endcase
   endtask

   task automatic set_delays(logic [7:0] low, logic [7:0] high, logic [7:0] half,
                             logic [7:0] settle, logic [7:0] start, logic [7:0] stop);
      wait_drained();
      write_csr(CSR_CLOCK_LOW, low);
      write_csr(CSR_CLOCK_HIGH, high);
      write_csr(CSR_HALF_CLOCK, half);
      write_csr(CSR_SETTLE, settle);
      write_csr(CSR_START, start);
      write_csr(CSR_STOP, stop);
   endtask

   initial begin
      logic [7:0] low;
      logic [7:0] high;
      logic [7:0] half;
      logic [7:0] settle;
      bus_cfg           = CFG_RESET;
      gen_state         = '0;
      gen_state.phase   = PH_IDLE;
      gen_state.scl     = 1'b1;
      gen_state.sda     = 1'b1;
      model_state       = gen_state;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // default delays; a command straight after start is ignored
      push_tick(CMD_START, 8'h00, 1'b0);
      push_tick(CMD_WRITE, 8'hFF, 1'b1);
      bus_traffic(200);

      // no waits at all: every sequence completes on its command tick
      set_delays(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      write_csr(CSR_UNMAPPED_LO, 8'hFF);
      write_csr(CSR_UNMAPPED_HI, 8'hAA);
      push_tick(CMD_NONE, 8'h00, 1'b0);
      push_tick(CMD_START, 8'h00, 1'b0);
      push_tick(CMD_WRITE, 8'hFF, 1'b0);
      push_tick(CMD_GET_ACK, 8'h00, 1'b0);
      push_tick(CMD_WRITE, 8'h00, 1'b1);
      push_tick(CMD_GET_ACK, 8'hFF, 1'b1);
      push_tick(CMD_READ, 8'h00, 1'b1);
      push_tick(CMD_SEND_ACK, 8'h00, 1'b0);
      push_tick(CMD_READ, 8'hFF, 1'b0);
      push_tick(CMD_SEND_NACK, 8'h00, 1'b1);
      push_tick(CMD_STOP, 8'h5A, 1'b1);
      push_tick(CMD_WRITE, 8'hA5, 1'b0);
      push_tick(CMD_STOP, 8'h00, 1'b0);
      bus_traffic(100);

      // longest waits: a stop, then an ack check that finds no ack
      set_delays(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_tick(CMD_STOP, 8'h00, 1'b1);
      settle_bus(1'b0);
      last_cmd = CMD_GET_ACK;
      push_tick(CMD_GET_ACK, 8'h00, 1'b1);
      settle_bus(1'b1);

      // bit loops without waits, start and stop still timed
      set_delays(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd2);
      bus_traffic(150);

      repeat (3) begin
         low    = 8'($urandom_range(0, 3));
         high   = 8'($urandom_range(0, 3));
         half   = 8'($urandom_range(0, 3));
         settle = 8'($urandom_range(0, 3));
         if ($urandom_range(0, 2) == 0) begin
            low    = 8'd0;
            high   = 8'd0;
            half   = 8'd0;
            settle = 8'd0;
         end
         set_delays(low, high, half, settle, 8'($urandom_range(0, 3)),
                    8'($urandom_range(0, 3)));
         bus_traffic(150);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0 && bus_forecast.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/i2cmbe_pkg.sv
hdl/i2c_master_bit_engine.sv
tb/i2c_master_bit_engine_tb.sv
